// ----- hw/rtl/sgw_pkg.sv -----
// ----------------------------------------------------------------------------
// sgw_pkg: shared types and constants of the Sobel gradient window stream
// Pixel and result widths, frame limits, register codes and window types.
// ----------------------------------------------------------------------------
package sgw_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int MIN_DIM      = 3;

    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 8;
    localparam int OUT_POS_W = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(HEIGHT_LIMIT);
    localparam int LIMIT_W  = $clog2(MAX_WIDTH + 1);
    localparam int HLIMIT_W = $clog2(HEIGHT_LIMIT + 1);

    localparam int WIDTH_RESET  = 642;
    localparam int HEIGHT_RESET = 482;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PADDED_WIDTH,
        REG_PADDED_HEIGHT
    } cfg_reg_t;

    // One column of the 3x3 window: top, middle and bottom pixel.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    typedef struct packed {
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } position_t;

endpackage

// ----- hw/rtl/sgw_pixel_if.sv -----
// ----------------------------------------------------------------------------
// sgw_pixel_if: pixel stream channel
// Valid/ready channel that carries one padded-frame pixel per beat.
// ----------------------------------------------------------------------------
interface sgw_pixel_if import sgw_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

// ----- hw/rtl/sgw_result_if.sv -----
// ----------------------------------------------------------------------------
// sgw_result_if: gradient result channel
// Valid/ready channel that carries one Sobel result and its position per beat.
// ----------------------------------------------------------------------------
interface sgw_result_if import sgw_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [MAG_W-1:0]         magnitude;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [OUT_POS_W-1:0]     out_row;
    logic [OUT_POS_W-1:0]     out_col;

    modport source (output valid, output magnitude, output grad_x, output grad_y,
                    output out_row, output out_col, input ready);
    modport sink   (input valid, input magnitude, input grad_x, input grad_y,
                    input out_row, input out_col, output ready);

endinterface

// ----- hw/rtl/sgw_line_buffer.sv -----
// ----------------------------------------------------------------------------
// sgw_line_buffer: two row delays feeding the newest window column
// Holds the previous two rows by column and prefetches the next column's taps.
// ----------------------------------------------------------------------------
module sgw_line_buffer import sgw_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [COL_W-1:0] rd_addr,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [PIX_W-1:0] pixel,
    output logic [PIX_W-1:0] tap_top,
    output logic [PIX_W-1:0] tap_mid
);

    logic [PIX_W-1:0] row_one_mem [MAX_WIDTH];
    logic [PIX_W-1:0] row_two_mem [MAX_WIDTH];
    logic [PIX_W-1:0] tap_one_reg;
    logic [PIX_W-1:0] tap_two_reg;

    // The taps are read ahead at the next column. The entry of the
    // first row delay at the current column is therefore already in
    // tap_one_reg, and moves down into the second row delay from there.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            row_one_mem[wr_addr] <= pixel;
            row_two_mem[wr_addr] <= tap_one_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_one_reg <= '0;
            tap_two_reg <= '0;
        end
        else if (shift)
        begin
            tap_one_reg <= row_one_mem[rd_addr];
            tap_two_reg <= row_two_mem[rd_addr];
        end
    end

    assign tap_top = tap_two_reg;
    assign tap_mid = tap_one_reg;

endmodule

// ----- hw/rtl/sgw_cell.sv -----
// ----------------------------------------------------------------------------
// sgw_cell: one column of the 3x3 window
// Takes the column on its right each beat and offers it to the cell on its left.
// ----------------------------------------------------------------------------
module sgw_cell import sgw_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  column_t column_in,
    output column_t column_out
);

    column_t column_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
        end
        else if (shift)
        begin
            column_reg <= column_in;
        end
    end

    assign column_out = column_reg;

endmodule

// ----- hw/rtl/sgw_kernel.sv -----
// ----------------------------------------------------------------------------
// sgw_kernel: Sobel sums and magnitude
// Two-stage pipeline: gradients from the window, then saturated magnitude.
// ----------------------------------------------------------------------------
module sgw_kernel import sgw_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  column_t             left,
    input  column_t             centre,
    input  column_t             right,
    input  position_t           pos,
    sgw_result_if.source        results
);

    logic                     s1_valid_reg;
    logic signed [GRAD_W-1:0] gx_reg;
    logic signed [GRAD_W-1:0] gy_reg;
    position_t                s1_pos_reg;

    logic                     out_valid_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [GRAD_W-1:0] out_gx_reg;
    logic signed [GRAD_W-1:0] out_gy_reg;
    position_t                out_pos_reg;

    logic                     out_free;
    logic                     s1_free;
    logic signed [GRAD_W-1:0] gx_next;
    logic signed [GRAD_W-1:0] gy_next;
    logic [GRAD_W-1:0]        abs_gx;
    logic [GRAD_W-1:0]        abs_gy;
    logic [GRAD_W:0]          abs_sum;
    logic [GRAD_W-2:0]        mag_wide;
    logic [MAG_W-1:0]         mag_next;

    assign out_free = !out_valid_reg || results.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign in_ready = s1_free;

    // Results stay within eleven bits, so the sums may wrap on the way.
    always_comb
    begin
        gx_next = (GRAD_W'(right.top) + (GRAD_W'(right.mid) << 1) + GRAD_W'(right.bot))
                - (GRAD_W'(left.top) + (GRAD_W'(left.mid) << 1) + GRAD_W'(left.bot));
        gy_next = (GRAD_W'(left.bot) + (GRAD_W'(centre.bot) << 1) + GRAD_W'(right.bot))
                - (GRAD_W'(left.top) + (GRAD_W'(centre.top) << 1) + GRAD_W'(right.top));
    end

    always_comb
    begin
        abs_gx   = gx_reg[GRAD_W-1] ? GRAD_W'(-gx_reg) : GRAD_W'(gx_reg);
        abs_gy   = gy_reg[GRAD_W-1] ? GRAD_W'(-gy_reg) : GRAD_W'(gy_reg);
        abs_sum  = {1'b0, abs_gx} + {1'b0, abs_gy};
        mag_wide = abs_sum[GRAD_W:2];
        mag_next = (mag_wide > (GRAD_W-1)'(MAG_MAX)) ? MAG_MAX : mag_wide[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            s1_pos_reg <= pos;
        end
        if (out_free && s1_valid_reg)
        begin
            mag_reg     <= mag_next;
            out_gx_reg  <= gx_reg;
            out_gy_reg  <= gy_reg;
            out_pos_reg <= s1_pos_reg;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.magnitude = mag_reg;
    assign results.grad_x    = out_gx_reg;
    assign results.grad_y    = out_gy_reg;
    assign results.out_row   = out_pos_reg.row;
    assign results.out_col   = out_pos_reg.col;

endmodule

// ----- hw/rtl/sobel_gradient_window_stream.sv -----
// ----------------------------------------------------------------------------
// sobel_gradient_window_stream: 3x3 Sobel gradients over a padded pixel stream
// Line buffers, a chain of window columns and a two-stage gradient kernel.
// ----------------------------------------------------------------------------
// The block takes one pixel of a zero-padded frame per clock while it is ready,
// in raster order, and gives one result for every pixel at padded row and
// column of two or more: the Sobel sums grad_x and grad_y, the magnitude
// (|gx|+|gy|)/4 clipped to 255, and the window centre in unpadded coordinates.
// Each result passes the gradient and then the magnitude stage. The input is
// held off only when both kernel stages are full and the result beat is not
// taken; the rate is set by one read and one write of each row delay per beat,
// at different columns, which allows one pixel every clock. Frame width and
// height are taken from the configuration registers, clipped to 3..1024, and
// should change only between frames; the row delays hold stale data after
// reset, which the first two padded rows overwrite before any result uses them.
module sobel_gradient_window_stream import sgw_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    sgw_pixel_if.sink            pixels,
    sgw_result_if.source         results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [LIMIT_W-1:0]  width_reg;
    logic [HLIMIT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic [LIMIT_W-1:0]  width_next;
    logic [HLIMIT_W-1:0] height_next;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_next;
    logic                col_last;
    logic                row_last;
    logic                accept;
    logic                emit;
    logic                kernel_ready;
    logic [PIX_W-1:0]    tap_top;
    logic [PIX_W-1:0]    tap_mid;
    column_t             column_new;
    column_t             column_centre;
    column_t             column_left;
    position_t           pos;

    always_comb
    begin
        if (int'(cfg_data) < MIN_DIM)
        begin
            width_next  = LIMIT_W'(MIN_DIM);
            height_next = HLIMIT_W'(MIN_DIM);
        end
        else
        begin
            width_next  = (int'(cfg_data) > MAX_WIDTH) ? LIMIT_W'(MAX_WIDTH)
                                                      : LIMIT_W'(cfg_data);
            height_next = (int'(cfg_data) > HEIGHT_LIMIT) ? HLIMIT_W'(HEIGHT_LIMIT)
                                                         : HLIMIT_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= LIMIT_W'(WIDTH_RESET);
            height_reg <= HLIMIT_W'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PADDED_WIDTH:  width_reg  <= width_next;
                REG_PADDED_HEIGHT: height_reg <= height_next;
                default:           ;
            endcase
        end
    end

    assign accept = pixels.valid && kernel_ready;
    assign pixels.ready = kernel_ready;

    // A column at or beyond a narrowed width still wraps to the next row.
    always_comb
    begin
        col_last = (LIMIT_W'(col_reg) + LIMIT_W'(1)) >= width_reg;
        row_last = (HLIMIT_W'(row_reg) + HLIMIT_W'(1)) >= height_reg;
        col_next = col_last ? '0 : col_reg + COL_W'(1);
        if (!col_last)
        begin
            row_next = row_reg;
        end
        else
        begin
            row_next = row_last ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign emit    = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign pos.row = OUT_POS_W'(row_reg - ROW_W'(2));
    assign pos.col = OUT_POS_W'(col_reg - COL_W'(2));

    sgw_line_buffer u_line_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (accept),
        .rd_addr (col_next),
        .wr_addr (col_reg),
        .pixel   (pixels.pixel),
        .tap_top (tap_top),
        .tap_mid (tap_mid)
    );

    assign column_new.top = tap_top;
    assign column_new.mid = tap_mid;
    assign column_new.bot = pixels.pixel;

    sgw_cell u_cell_centre (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept),
        .column_in  (column_new),
        .column_out (column_centre)
    );

    sgw_cell u_cell_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept),
        .column_in  (column_centre),
        .column_out (column_left)
    );

    sgw_kernel u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept && emit),
        .in_ready (kernel_ready),
        .left     (column_left),
        .centre   (column_centre),
        .right    (column_new),
        .pos      (pos),
        .results  (results)
    );

endmodule

// ----- hw/rtl/sgw_checker.sv -----
// ----------------------------------------------------------------------------
// sgw_checker: assertions on the result port of the gradient stream
// Checks held beats, gradient range, magnitude and position bounds.
// ----------------------------------------------------------------------------
module sgw_checker import sgw_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     valid,
    input logic                     ready,
    input logic [MAG_W-1:0]         magnitude,
    input logic signed [GRAD_W-1:0] grad_x,
    input logic signed [GRAD_W-1:0] grad_y,
    input logic [OUT_POS_W-1:0]     out_row,
    input logic [OUT_POS_W-1:0]     out_col
);

    localparam int GRAD_LIMIT = 4 * ((1 << PIX_W) - 1);
    localparam int ROW_LIMIT  = HEIGHT_LIMIT - 3;
    localparam int COL_LIMIT  = MAX_WIDTH - 3;

    logic [GRAD_W-1:0] abs_gx;
    logic [GRAD_W-1:0] abs_gy;
    logic [GRAD_W:0]   abs_sum;
    logic [MAG_W-1:0]  expected_mag;

    always_comb
    begin
        abs_gx       = grad_x[GRAD_W-1] ? GRAD_W'(-grad_x) : GRAD_W'(grad_x);
        abs_gy       = grad_y[GRAD_W-1] ? GRAD_W'(-grad_y) : GRAD_W'(grad_y);
        abs_sum      = {1'b0, abs_gx} + {1'b0, abs_gy};
        expected_mag = (abs_sum[GRAD_W:2] > (GRAD_W-1)'(MAG_MAX)) ? MAG_MAX
                                                                 : abs_sum[MAG_W+1:2];
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid
            && $stable({magnitude, grad_x, grad_y, out_row, out_col}))
        else $error("result beat changed while stalled");

    a_grad_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> int'(grad_x) >= -GRAD_LIMIT && int'(grad_x) <= GRAD_LIMIT
               && int'(grad_y) >= -GRAD_LIMIT && int'(grad_y) <= GRAD_LIMIT)
        else $error("gradient outside the Sobel range");

    a_magnitude: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> magnitude == expected_mag)
        else $error("magnitude does not match the gradients");

    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> int'(out_row) <= ROW_LIMIT && int'(out_col) <= COL_LIMIT)
        else $error("result position outside the unpadded frame");

endmodule

bind sobel_gradient_window_stream sgw_checker u_sgw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (results.valid),
    .ready     (results.ready),
    .magnitude (results.magnitude),
    .grad_x    (results.grad_x),
    .grad_y    (results.grad_y),
    .out_row   (results.out_row),
    .out_col   (results.out_col)
);
